@@ rtl/piq_pkg.sv @@
// Package for the positional insert queue: sizes, payload structs, opcodes
// and the command word passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package piq_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_WIDTH = 16;
    localparam int OCC_W    = $clog2(DEPTH + 1);
    localparam int SLOT_W   = $clog2(DEPTH);
    localparam int POS_W    = 4;
    localparam int ENTRY_W  = 16;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_NEXT   = 2'd1,
        OP_STATUS = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               has_position;
        logic [POS_W-1:0]   position;
        logic [ENTRY_W-1:0] entry_id;
    } in_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_value;
        logic               queue_empty;
        logic               last_of_report;
    } out_t;

    // pos_idx is the 0-based target slot; position zero already folded to the front
    typedef struct packed {
        cmd_kind_t           kind;
        logic                has_pos;
        logic [POS_W-1:0]    pos_idx;
        logic [ID_WIDTH-1:0] id;
    } cmd_t;

endpackage

@@ rtl/piq_front.sv @@
// Front end: accepts input transactions, drops unused opcodes and turns
// the rest into command words. Depends on piq_pkg.
`timescale 1ns / 1ps

module piq_front import piq_pkg::*; (
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic cmd_push,
    output cmd_t cmd_data,
    input  logic cmd_full
);

    logic accept;

    assign s_ready = !cmd_full;
    assign accept  = s_valid && !cmd_full;

    // unused opcode is accepted and swallowed here
    always_comb begin
        cmd_data.kind    = CMD_ADD;
        cmd_data.has_pos = s_data.has_position;
        cmd_data.pos_idx = (s_data.position == '0) ? '0 : s_data.position - POS_W'(1);
        cmd_data.id      = ID_WIDTH'(s_data.entry_id);
        cmd_push         = 1'b0;
        case (opcode_t'(s_data.opcode))
            OP_ADD: begin
                cmd_data.kind = CMD_ADD;
                cmd_push      = accept;
            end
            OP_NEXT: begin
                cmd_data.kind = CMD_REMOVE;
                cmd_push      = accept;
            end
            OP_STATUS: begin
                cmd_data.kind = CMD_REPORT;
                cmd_push      = accept;
            end
            default: begin
                cmd_push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/piq_cmd_fifo.sv @@
// Short command queue between front end and back end.
// Depends on piq_pkg.
`timescale 1ns / 1ps

module piq_cmd_fifo import piq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic cmd_valid,
    output cmd_t cmd_data
);

    cmd_t                mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + CQ_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + CQ_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CQ_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/piq_back.sv @@
// Back end: slot registers with parallel shift for insert/remove, report
// sequencer and output register. Depends on piq_pkg.
`timescale 1ns / 1ps

module piq_back import piq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    input  cmd_t cmd_data,
    output logic cmd_pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [ID_WIDTH-1:0] slots_reg [DEPTH];
    logic [ID_WIDTH-1:0] slots_next [DEPTH];
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;
    logic                out_free;
    logic [OCC_W-1:0]    at;
    logic                rpt_last;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    assign at = (cmd_data.has_pos && (OCC_W'(cmd_data.pos_idx) < occ_reg))
              ? OCC_W'(cmd_data.pos_idx) : occ_reg;
    assign rpt_last = ((OCC_W'(idx_reg) + OCC_W'(1)) == occ_reg);

    always_comb begin
        state_next     = state_reg;
        slots_next     = slots_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        cmd_pop        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd_data.kind)
                        CMD_ADD: begin
                            cmd_pop = 1'b1;
                            // full queue drops the add
                            if (occ_reg < OCC_W'(DEPTH)) begin
                                for (int i = 1; i < DEPTH; i++) begin
                                    if (OCC_W'(i) > at) begin
                                        slots_next[i] = slots_reg[i-1];
                                    end
                                end
                                slots_next[at[SLOT_W-1:0]] = cmd_data.id;
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            cmd_pop = 1'b1;
                            if (occ_reg != '0) begin
                                for (int i = 0; i < DEPTH - 1; i++) begin
                                    slots_next[i] = slots_reg[i+1];
                                end
                                occ_next = occ_reg - OCC_W'(1);
                            end
                        end
                        CMD_REPORT: begin
                            if (occ_reg == '0) begin
                                if (out_free) begin
                                    cmd_pop                      = 1'b1;
                                    out_valid_next               = 1'b1;
                                    out_data_next.entry_value    = '0;
                                    out_data_next.queue_empty    = 1'b1;
                                    out_data_next.last_of_report = 1'b1;
                                end
                            end else begin
                                cmd_pop    = 1'b1;
                                idx_next   = '0;
                                state_next = ST_REPORT;
                            end
                        end
                        default: begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    out_valid_next               = 1'b1;
                    out_data_next.entry_value    = ENTRY_W'(slots_reg[idx_reg]);
                    out_data_next.queue_empty    = 1'b0;
                    out_data_next.last_of_report = rpt_last;
                    idx_next                     = idx_reg + SLOT_W'(1);
                    if (rpt_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slots_reg    <= slots_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/positional_insert_queue.sv @@
// Positional insert queue, top level: front end, command queue, back end.
// Add and next: queued, then applied to the slots; one per cycle unless a status
// report holds the back end. Status: one empty result on an empty queue, else the
// report sequencer gives one per entry, one per cycle unless stalled (one slot read port).
// Reset (aresetn, synchronous, active low) empties the queue; slot contents stay.
`timescale 1ns / 1ps

module positional_insert_queue import piq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic cmd_push, cmd_full, cmd_pop, cmd_valid;
    cmd_t cmd_in, cmd_out;

    piq_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in),
        .cmd_full (cmd_full)
    );

    piq_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_out)
    );

    piq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ rtl/piq_checker.sv @@
// Port-level checker for positional_insert_queue, bound to the top level.
// Depends on piq_pkg.
`timescale 1ns / 1ps

module piq_checker import piq_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while stalled");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.queue_empty |->
            m_data.last_of_report && (m_data.entry_value == '0))
        else $error("malformed empty report");

    // an empty-queue result never appears in the middle of a report
    a_no_empty_midreport: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_report |=>
            !(m_valid && m_data.queue_empty))
        else $error("empty flag inside a running report");

endmodule

bind positional_insert_queue piq_checker u_piq_checker (.*);
